/* hw/rtl/mpt_pkg.sv */
package mpt_pkg;

  localparam int unsigned NumSides   = 2;
  localparam int unsigned NumRegions = 16;
  localparam int unsigned MaskW      = 32;
  localparam int unsigned CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MASK_RIGHT_LOW  = 2'd0,
    REG_MASK_LEFT_LOW   = 2'd1,
    REG_MASK_RIGHT_HIGH = 2'd2,
    REG_MASK_LEFT_HIGH  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] right_regions;
    logic [63:0] left_regions;
  } in_t;

  typedef struct packed {
    logic single_low;
    logic single_high;
    logic like_pair_low;
    logic like_pair_high;
    logic unlike_pair_low;
    logic unlike_pair_high;
  } out_t;

  // mask applies to the pair-swapped nibble, so bit i meets mask bit i^1
  function automatic logic [3:0] mask_nibble(logic [3:0] b, logic [3:0] m);
    return b & {m[2], m[3], m[0], m[1]};
  endfunction

  // bit0 like, bit1 unlike, bits 3:2 single flags
  function automatic logic [3:0] merge_nibble(logic [3:0] a, logic [3:0] b);
    logic lk;
    logic ul;
    lk = (a[2] & b[2]) | (a[3] & b[3]) | a[0] | b[0];
    ul = (a[2] & b[3]) | (a[3] & b[2]) | a[1] | b[1];
    return {a[3] | b[3], a[2] | b[2], ul, lk};
  endfunction

  function automatic logic [7:0] merge_pair(logic [7:0] a, logic [7:0] b);
    return {merge_nibble(a[7:4], b[7:4]), merge_nibble(a[3:0], b[3:0])};
  endfunction

endpackage

/* hw/rtl/muon_pair_trigger_tree_unit.sv */
// Stages advance on their own enables; a word is registered in each in turn.
// Throughput: one word per cycle while out_stall_i is low; three register
// stages: masking, two tree levels, two tree levels plus root decode.
// Reset: all stage valid bits cleared, the four mask registers set to all ones.
module muon_pair_trigger_tree_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mpt_pkg::in_t                 in_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  output mpt_pkg::out_t                out_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic                         cfg_we_i,
  input  logic [mpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mpt_pkg::MaskW-1:0]    cfg_data_i
);
  import mpt_pkg::*;

  logic [MaskW-1:0] mask_rl_q, mask_ll_q, mask_rh_q, mask_lh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_rl_q <= '1;
      mask_ll_q <= '1;
      mask_rh_q <= '1;
      mask_lh_q <= '1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MASK_RIGHT_LOW:  mask_rl_q <= cfg_data_i;
        REG_MASK_LEFT_LOW:   mask_ll_q <= cfg_data_i;
        REG_MASK_RIGHT_HIGH: mask_rh_q <= cfg_data_i;
        REG_MASK_LEFT_HIGH:  mask_lh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when empty or when its successor moves
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: masked leaves
  logic [NumRegions-1:0][7:0] s1_d, s1_q;

  always_comb begin
    for (int r = 0; r < NumRegions/NumSides; r++) begin
      s1_d[r] = {mask_nibble(in_i.right_regions[8*r+4 +: 4], mask_rh_q[4*r +: 4]),
                 mask_nibble(in_i.right_regions[8*r   +: 4], mask_rl_q[4*r +: 4])};
      s1_d[r+NumRegions/NumSides] =
                {mask_nibble(in_i.left_regions[8*r+4 +: 4], mask_lh_q[4*r +: 4]),
                 mask_nibble(in_i.left_regions[8*r   +: 4], mask_ll_q[4*r +: 4])};
    end
  end

  // stage 2: tree levels one and two
  logic [7:0][7:0] lvl1;
  logic [3:0][7:0] s2_d, s2_q;

  always_comb begin
    for (int n = 0; n < 8; n++) lvl1[n] = merge_pair(s1_q[2*n], s1_q[2*n+1]);
    for (int n = 0; n < 4; n++) s2_d[n] = merge_pair(lvl1[2*n], lvl1[2*n+1]);
  end

  // stage 3: tree levels three and four, root decode
  logic [1:0][7:0] lvl3;
  logic [7:0]      root;
  out_t            s3_d, s3_q;

  always_comb begin
    for (int n = 0; n < 2; n++) lvl3[n] = merge_pair(s2_q[2*n], s2_q[2*n+1]);
    root                  = merge_pair(lvl3[0], lvl3[1]);
    s3_d.single_low       = |root[3:2];
    s3_d.single_high      = |root[7:6];
    s3_d.like_pair_low    = root[0];
    s3_d.like_pair_high   = root[4];
    s3_d.unlike_pair_low  = root[1];
    s3_d.unlike_pair_high = root[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q <= s1_d;
    if (en2 && v1_q)       s2_q <= s2_d;
    if (en3 && v2_q)       s3_q <= s3_d;
  end

  assign out_o       = s3_q;
  assign out_valid_o = v3_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free stage");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled while output is free");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !out_stall_i) |=> out_valid_o)
    else $error("word lost between tree stages");

endmodule
